/* hw/rtl/rvdec_pkg.sv */
// Package for the RV32I instruction decoder: opcodes, field codes and the
// decoded record type. No dependencies.
package rvdec_pkg;

   localparam logic [6:0] OPC_OP     = 7'h33;
   localparam logic [6:0] OPC_OP_IMM = 7'h13;
   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_JALR   = 7'h67;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_BRANCH = 7'h63;
   localparam logic [6:0] OPC_LUI    = 7'h37;
   localparam logic [6:0] OPC_AUIPC  = 7'h17;
   localparam logic [6:0] OPC_JAL    = 7'h6f;

   localparam logic [6:0]  FUNCT7_ZERO = 7'h00;
   localparam logic [6:0]  FUNCT7_ALT  = 7'h20;
   localparam logic [11:0] END_MARK_IMM = 12'd255;
   localparam logic [31:0] UPPER_MASK   = 32'hffff_f000;

   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 96;
   localparam int RSP_USER_W = 4;

   typedef enum logic [2:0] {
      CLS_CALC   = 3'd0,
      CLS_LOAD   = 3'd1,
      CLS_STORE  = 3'd2,
      CLS_BRANCH = 3'd3,
      CLS_END    = 3'd4
   } ins_class_type;

   typedef enum logic [3:0] {
      ALU_ADD  = 4'd0,
      ALU_SUB  = 4'd1,
      ALU_SLL  = 4'd2,
      ALU_SLT  = 4'd3,
      ALU_SLTU = 4'd4,
      ALU_XOR  = 4'd5,
      ALU_SRL  = 4'd6,
      ALU_SRA  = 4'd7,
      ALU_OR   = 4'd8,
      ALU_AND  = 4'd9,
      ALU_PASS = 4'd10
   } alu_op_type;

   typedef enum logic [2:0] {
      BR_BEQ  = 3'd0,
      BR_BNE  = 3'd1,
      BR_BLT  = 3'd2,
      BR_BGE  = 3'd3,
      BR_BLTU = 3'd4,
      BR_BGEU = 3'd5,
      BR_JAL  = 3'd6,
      BR_JALR = 3'd7
   } branch_kind_type;

   typedef enum logic [2:0] {
      ACC_BYTE   = 3'd0,
      ACC_HALF   = 3'd1,
      ACC_WORD   = 3'd2,
      ACC_BYTE_U = 3'd3,
      ACC_HALF_U = 3'd4
   } access_mode_type;

   typedef enum logic [1:0] {
      SEL_REG_REG = 2'd0,
      SEL_REG_IMM = 2'd1,
      SEL_PC_IMM  = 2'd2
   } operand_select_type;

   typedef struct packed {
      logic               illegal;
      ins_class_type      ins_class;
      alu_op_type         alu_op;
      branch_kind_type    branch_kind;
      access_mode_type    access_mode;
      operand_select_type operand_select;
      logic               writes_rd;
      logic [4:0]         src1_reg;
      logic [4:0]         src2_reg;
      logic [4:0]         dest_reg;
      logic signed [31:0] immediate;
      logic [31:0]        jump_target;
   } decode_type;

   function automatic alu_op_type alu_by_funct3(input logic [2:0] f3);
      alu_op_type op;
      case (f3)
         3'd0: op = ALU_ADD;
         3'd1: op = ALU_SLL;
         3'd2: op = ALU_SLT;
         3'd3: op = ALU_SLTU;
         3'd4: op = ALU_XOR;
         3'd5: op = ALU_SRL;
         3'd6: op = ALU_OR;
         default: op = ALU_AND;
      endcase
      return op;
   endfunction

endpackage

/* hw/rtl/rvdec_decode.sv */
// Combinational RV32I decode of one instruction word and its pc into the
// decoded record. Depends on rvdec_pkg.
module rvdec_decode import rvdec_pkg::*; (
   input  logic [31:0] instruction,
   input  logic [31:0] fetch_pc,
   output decode_type  result
);

   logic [6:0]  opc;
   logic [2:0]  f3;
   logic [6:0]  f7;
   logic [31:0] imm_i;
   logic [31:0] imm_s;
   logic [31:0] imm_b;
   logic [31:0] imm_j;
   logic [31:0] imm_shamt;
   decode_type  dec;

   assign opc = instruction[6:0];
   assign f3  = instruction[14:12];
   assign f7  = instruction[31:25];

   assign imm_i = {{20{instruction[31]}}, instruction[31:20]};
   assign imm_s = {{20{instruction[31]}}, instruction[31:25], instruction[11:7]};
   assign imm_b = {{19{instruction[31]}}, instruction[31], instruction[7],
                   instruction[30:25], instruction[11:8], 1'b0};
   assign imm_j = {{11{instruction[31]}}, instruction[31], instruction[19:12],
                   instruction[20], instruction[30:21], 1'b0};
   assign imm_shamt = {27'd0, instruction[24:20]};

   always_comb begin
      dec                = '0;
      dec.ins_class      = CLS_CALC;
      dec.alu_op         = ALU_ADD;
      dec.branch_kind    = BR_BEQ;
      dec.access_mode    = ACC_BYTE;
      dec.operand_select = SEL_REG_REG;
      case (opc)
         OPC_OP: begin
            dec.writes_rd = 1'b1;
            if (f7 == FUNCT7_ZERO) begin
               dec.alu_op = alu_by_funct3(f3);
            end else if (f7 == FUNCT7_ALT && f3 == 3'd0) begin
               dec.alu_op = ALU_SUB;
            end else if (f7 == FUNCT7_ALT && f3 == 3'd5) begin
               dec.alu_op = ALU_SRA;
            end else begin
               dec.illegal = 1'b1;
            end
         end
         OPC_OP_IMM: begin
            dec.operand_select = SEL_REG_IMM;
            dec.writes_rd      = 1'b1;
            dec.alu_op         = alu_by_funct3(f3);
            dec.immediate      = imm_i;
            if (f3 == 3'd1) begin
               dec.immediate = imm_shamt;
               if (f7 != FUNCT7_ZERO) dec.illegal = 1'b1;
            end else if (f3 == 3'd5) begin
               dec.immediate = imm_shamt;
               if (f7 == FUNCT7_ALT) dec.alu_op = ALU_SRA;
               else if (f7 != FUNCT7_ZERO) dec.illegal = 1'b1;
            end else if (f3 == 3'd0 && instruction[31:20] == END_MARK_IMM) begin
               dec.ins_class = CLS_END;
            end
         end
         OPC_LOAD: begin
            dec.ins_class      = CLS_LOAD;
            dec.operand_select = SEL_REG_IMM;
            dec.writes_rd      = 1'b1;
            dec.immediate      = imm_i;
            case (f3)
               3'd0: dec.access_mode = ACC_BYTE;
               3'd1: dec.access_mode = ACC_HALF;
               3'd2: dec.access_mode = ACC_WORD;
               3'd4: dec.access_mode = ACC_BYTE_U;
               3'd5: dec.access_mode = ACC_HALF_U;
               default: dec.illegal = 1'b1;
            endcase
         end
         OPC_JALR: begin
            dec.ins_class      = CLS_BRANCH;
            dec.branch_kind    = BR_JALR;
            dec.operand_select = SEL_REG_IMM;
            dec.writes_rd      = 1'b1;
            dec.immediate      = imm_i;
            if (f3 != 3'd0) dec.illegal = 1'b1;
         end
         OPC_STORE: begin
            dec.ins_class      = CLS_STORE;
            dec.operand_select = SEL_REG_IMM;
            dec.immediate      = imm_s;
            case (f3)
               3'd0: dec.access_mode = ACC_BYTE;
               3'd1: dec.access_mode = ACC_HALF;
               3'd2: dec.access_mode = ACC_WORD;
               default: dec.illegal = 1'b1;
            endcase
         end
         OPC_BRANCH: begin
            dec.ins_class = CLS_BRANCH;
            dec.immediate = imm_b;
            case (f3)
               3'd0: dec.branch_kind = BR_BEQ;
               3'd1: dec.branch_kind = BR_BNE;
               3'd4: dec.branch_kind = BR_BLT;
               3'd5: dec.branch_kind = BR_BGE;
               3'd6: dec.branch_kind = BR_BLTU;
               3'd7: dec.branch_kind = BR_BGEU;
               default: dec.illegal = 1'b1;
            endcase
         end
         OPC_LUI: begin
            dec.alu_op         = ALU_PASS;
            dec.operand_select = SEL_REG_IMM;
            dec.writes_rd      = 1'b1;
            dec.immediate      = instruction & UPPER_MASK;
         end
         OPC_AUIPC: begin
            dec.operand_select = SEL_PC_IMM;
            dec.writes_rd      = 1'b1;
            dec.immediate      = instruction & UPPER_MASK;
         end
         OPC_JAL: begin
            dec.ins_class      = CLS_BRANCH;
            dec.branch_kind    = BR_JAL;
            dec.operand_select = SEL_PC_IMM;
            dec.writes_rd      = 1'b1;
            dec.immediate      = imm_j;
            dec.jump_target    = fetch_pc + imm_j;
         end
         default: begin
            dec.illegal = 1'b1;
         end
      endcase

      // drop every decoded field but the register indices of an unrecognized encoding
      if (dec.illegal) begin
         dec                = '0;
         dec.illegal        = 1'b1;
         dec.ins_class      = CLS_CALC;
         dec.alu_op         = ALU_ADD;
         dec.branch_kind    = BR_BEQ;
         dec.access_mode    = ACC_BYTE;
         dec.operand_select = SEL_REG_REG;
      end

      dec.src1_reg = instruction[19:15];
      dec.src2_reg = instruction[24:20];
      dec.dest_reg = instruction[11:7];
      result       = dec;
   end

endmodule

/* hw/rtl/rv32i_instruction_decoder_core.sv */
// RV32I instruction decoder core: input register, decode logic, result
// register. Depends on rvdec_pkg and rvdec_decode.
//
// Usage:
//   req channel carries one instruction transaction: tdata holds the
//   instruction word and its fetch pc. rsp channel carries one decoded
//   record per request: tuser flags illegal encodings and gives the
//   instruction class, tdata carries the control fields, register indices,
//   immediate and JAL target.
//   A request is held in the input register, then decoded into the result
//   register, which drives rsp. Throughput is one transaction per cycle while
//   the receiver takes each result; the path is one decode plus a 32-bit add
//   for the JAL target.
//   When the receiver stalls, the result register holds its record and the
//   input register still takes one more request, so req_tready only drops
//   once both registers are full. It rises again in the cycle the result
//   is taken.
//   Reset (synchronous, active high) empties both registers; payload
//   contents are left as they were.
module rv32i_instruction_decoder_core import rvdec_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [31:0] instruction, [63:32] fetch_pc
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [3:0] alu_op, [6:4] branch_kind, [9:7] access_mode, [11:10] operand_select,
   // [12] writes_rd, [17:13] src1_reg, [22:18] src2_reg, [27:23] dest_reg,
   // [59:28] immediate, [91:60] jump_target, [95:92] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // [0] illegal, [3:1] ins_class
   output logic [RSP_USER_W-1:0] rsp_tuser
);

   logic        in_valid_ff;
   logic        in_valid_in;
   logic [31:0] ins_ff;
   logic [31:0] pc_ff;
   logic        out_valid_ff;
   logic        out_valid_in;
   decode_type  out_ff;
   decode_type  dec;
   logic        advance;
   logic        req_take;

   rvdec_decode u_decode (
      .instruction (ins_ff),
      .fetch_pc    (pc_ff),
      .result      (dec)
   );

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in  = req_take || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         ins_ff <= req_tdata[31:0];
         pc_ff  <= req_tdata[63:32];
      end
      if (advance) begin
         out_ff <= dec;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = {out_ff.ins_class, out_ff.illegal};
   assign rsp_tdata  = {4'd0, out_ff.jump_target, out_ff.immediate, out_ff.dest_reg,
                        out_ff.src2_reg, out_ff.src1_reg, out_ff.writes_rd,
                        out_ff.operand_select, out_ff.access_mode,
                        out_ff.branch_kind, out_ff.alu_op};

endmodule
